// File: rtl/core/frpm_pkg.sv
// shared types and codes of the failure record prune matcher
package frpm_pkg;

  localparam int unsigned KeyW  = 6;
  localparam int unsigned TaskW = 6;
  localparam int unsigned MaskW = 64;

  typedef enum logic {
    CMD_QUERY  = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ROBOT_TASK    = 2'd0,
    KIND_ROBOT_PAIR    = 2'd1,
    KIND_SPECIES_TASK  = 2'd2,
    KIND_SPECIES_PAIR  = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic [1:0]        entry_kind;
    logic [KeyW-1:0]   entry_key;
    logic [TaskW-1:0]  entry_task_first;
    logic [TaskW-1:0]  entry_task_second;
    logic              has_assignment;
    logic [KeyW-1:0]   query_robot;
    logic [KeyW-1:0]   query_species;
    logic [TaskW-1:0]  query_task;
    logic [MaskW-1:0]  assigned_tasks;
  } in_item_t;

  typedef struct packed {
    logic prune;
    logic table_full;
  } out_item_t;

  // one stored failure record
  typedef struct packed {
    kind_e            kind;
    logic [KeyW-1:0]  key;
    logic [TaskW-1:0] task_first;
    logic [TaskW-1:0] task_second;
  } rec_t;

  // query as it travels down the row of cells
  typedef struct packed {
    logic             active;
    logic [KeyW-1:0]  robot;
    logic [KeyW-1:0]  species;
    logic [TaskW-1:0] task_id;
  } query_t;

endpackage

// File: rtl/core/frpm_if.sv
// valid/ready channels of the failure record prune matcher
interface frpm_in_if;
  import frpm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frpm_out_if;
  import frpm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/frpm_cell.sv
// one cell: holds a record, matches the passing query and forwards it
module frpm_cell #(
  parameter int unsigned TASKS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  frpm_pkg::rec_t      wr_rec_i,
  input  logic                rec_valid_i,
  input  frpm_pkg::query_t    query_i,
  input  logic [TASKS-1:0]    mask_i,
  input  logic                match_i,
  output frpm_pkg::query_t    query_o,
  output logic [TASKS-1:0]    mask_o,
  output logic                match_o
);
  import frpm_pkg::*;

  localparam int unsigned IdxW = $clog2(TASKS);

  rec_t             rec_q;
  query_t           query_q;
  logic [TASKS-1:0] mask_q;
  logic             match_q;
  logic             hit;
  logic             key_eq;
  logic             first_eq;
  logic             second_eq;
  logic             first_in_mask;
  logic             second_in_mask;

  // task bits at or above TASKS count as clear
  function automatic logic mask_bit(input logic [TASKS-1:0] m, input logic [TaskW-1:0] t);
    logic r;
    r = 1'b0;
    if (32'(t) < TASKS) r = m[t[IdxW-1:0]];
    return r;
  endfunction

  always_comb begin
    first_eq       = (rec_q.task_first == query_i.task_id);
    second_eq      = (rec_q.task_second == query_i.task_id);
    first_in_mask  = mask_bit(mask_i, rec_q.task_first);
    second_in_mask = mask_bit(mask_i, rec_q.task_second);
    case (rec_q.kind)
      KIND_ROBOT_TASK: begin
        key_eq = (rec_q.key == query_i.robot);
        hit    = key_eq & first_eq;
      end
      KIND_ROBOT_PAIR: begin
        key_eq = (rec_q.key == query_i.robot);
        hit    = key_eq & ((first_eq & second_in_mask) | (second_eq & first_in_mask));
      end
      KIND_SPECIES_TASK: begin
        key_eq = (rec_q.key == query_i.species);
        hit    = key_eq & first_eq;
      end
      KIND_SPECIES_PAIR: begin
        key_eq = (rec_q.key == query_i.species);
        hit    = key_eq & ((first_eq & second_in_mask) | (second_eq & first_in_mask));
      end
      default: begin
        key_eq = 1'b0;
        hit    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rec_q <= wr_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
    end else begin
      query_q <= query_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q          <= mask_i;
    match_q         <= match_i | (query_i.active & rec_valid_i & hit);
  end

  assign query_o = query_q;
  assign mask_o  = mask_q;
  assign match_o = match_q;

endmodule

// File: rtl/core/frpm_chain.sv
// row of record cells with write decode and fill-count validity
module frpm_chain #(
  parameter int unsigned RECORDS = 64,
  parameter int unsigned TASKS   = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [$clog2(RECORDS+1)-1:0]   count_i,
  input  frpm_pkg::rec_t                 wr_rec_i,
  input  frpm_pkg::query_t               query_i,
  input  logic [TASKS-1:0]               mask_i,
  output logic                           done_o,
  output logic                           match_o
);
  import frpm_pkg::*;

  localparam int unsigned CntW = $clog2(RECORDS+1);

  query_t           query_w [RECORDS+1];
  logic [TASKS-1:0] mask_w  [RECORDS+1];
  logic             match_w [RECORDS+1];

  assign query_w[0] = query_i;
  assign mask_w[0]  = mask_i;
  assign match_w[0] = 1'b0;

  for (genvar i = 0; i < RECORDS; i++) begin : g_cell
    logic cell_wr;
    logic cell_valid;

    assign cell_wr    = wr_en_i & (count_i == CntW'(i));
    assign cell_valid = (count_i > CntW'(i));

    frpm_cell #(
      .TASKS (TASKS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (cell_wr),
      .wr_rec_i    (wr_rec_i),
      .rec_valid_i (cell_valid),
      .query_i     (query_w[i]),
      .mask_i      (mask_w[i]),
      .match_i     (match_w[i]),
      .query_o     (query_w[i+1]),
      .mask_o      (mask_w[i+1]),
      .match_o     (match_w[i+1])
    );
  end

  assign done_o  = query_w[RECORDS].active;
  assign match_o = match_w[RECORDS];

endmodule

// File: rtl/core/failure_record_prune_matcher.sv
// top level of the failure record prune matcher
//
// in_i carries one item per handshake: an insert adds a failure record to
// the next free cell of the row, a query asks whether the given robot,
// species, task and mask of assigned tasks hit any stored record.
// out_o returns exactly one item for every input item: prune for a query,
// table_full for an insert that found all RECORDS cells in use.
// An insert, or a query without an assignment, is answered from the output
// register in the cycle after it is accepted. A query with an assignment walks
// the row of cells one cell a cycle, through the register of every cell, and
// its result is then taken into the output register.
// One item is worked on at a time: a new item is taken once the previous
// one has finished, and while its result still waits in the output
// register only if the receiver takes that result in the same cycle.
// Reset empties the table (fill count to zero) and drops any item in
// flight; record contents are not cleared, cells past the fill count are
// ignored. A stalled receiver holds the result and blocks new items.
module failure_record_prune_matcher #(
  parameter int unsigned RECORDS = 64,
  parameter int unsigned TASKS   = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  frpm_in_if.sink           in_i,
  frpm_out_if.source        out_o
);
  import frpm_pkg::*;

  localparam int unsigned CntW = $clog2(RECORDS+1);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;
  logic             accept;
  logic             is_full;
  logic             wr_en;
  rec_t             wr_rec;
  query_t           launch;
  logic             chain_done;
  logic             chain_match;

  assign is_full = (count_q == CntW'(RECORDS));

  always_comb begin
    wr_rec.kind        = kind_e'(in_i.data.entry_kind);
    wr_rec.key         = in_i.data.entry_key;
    wr_rec.task_first  = in_i.data.entry_task_first;
    wr_rec.task_second = in_i.data.entry_kind[0] ? in_i.data.entry_task_second : '0;
    launch.robot       = in_i.data.query_robot;
    launch.species     = in_i.data.query_species;
    launch.task_id     = in_i.data.query_task;
    launch.active      = 1'b0;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    in_i.ready  = 1'b0;
    accept      = 1'b0;
    wr_en       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = ~out_valid_q | out_o.ready;
        accept     = in_i.valid & in_i.ready;
        if (accept) begin
          if (in_i.data.cmd == CMD_INSERT) begin
            out_valid_d           = 1'b1;
            out_data_d.prune      = 1'b0;
            out_data_d.table_full = is_full;
            if (!is_full) begin
              wr_en   = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end else if (in_i.data.has_assignment) begin
            state_d = ST_RUN;
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
          end
        end
      end
      ST_RUN: begin
        if (chain_done) begin
          out_valid_d           = 1'b1;
          out_data_d.prune      = chain_match;
          out_data_d.table_full = 1'b0;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // only a query with an assignment enters the row
  logic launch_active;
  assign launch_active = accept & (in_i.data.cmd == CMD_QUERY) & in_i.data.has_assignment;

  query_t launch_item;
  always_comb begin
    launch_item        = launch;
    launch_item.active = launch_active;
  end

  frpm_chain #(
    .RECORDS (RECORDS),
    .TASKS   (TASKS)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .count_i  (count_q),
    .wr_rec_i (wr_rec),
    .query_i  (launch_item),
    .mask_i   (in_i.data.assigned_tasks[TASKS-1:0]),
    .done_o   (chain_done),
    .match_o  (chain_match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTH
  a_no_accept_while_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !in_i.ready)
    else $error("item accepted while a query walks the row");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RECORDS))
    else $error("fill count beyond table size");

  a_done_only_when_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_done |-> (state_q == ST_RUN) && !out_valid_q)
    else $error("row result with no query waiting or output slot busy");

  a_count_moves_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(wr_en))
    else $error("fill count changed without an insert");
`endif

endmodule

// File: test/failure_record_prune_matcher_test.sv
`timescale 1ns / 1ps
// self-checking bench of the failure record prune matcher: directed rows, then random items
module failure_record_prune_matcher_test;
  import frpm_pkg::*;

  localparam int unsigned NumRecords  = 64;
  localparam int unsigned NumTasks    = 64;
  localparam int unsigned PhaseItems  = 188;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = NumRecords + 16;

  localparam out_item_t NoVerdict = '{prune: 1'b0, table_full: 1'b0};

  typedef struct {
    in_item_t stim;
    logic     typed;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  frpm_in_if  req_ch ();
  frpm_out_if rsp_ch ();

  failure_record_prune_matcher #(
    .RECORDS(NumRecords),
    .TASKS  (NumTasks)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (rsp_ch.source)
  );

  rec_t        fail_log [NumRecords];
  int unsigned fail_count;
  out_item_t   expected_verdicts [$];
  out_item_t   oldest_verdict;
  stim_row_t   directed [$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  int unsigned phase_send_idle [4] = '{0, 73, 0, 31};
  int unsigned phase_recv_stall [4] = '{0, 0, 73, 31};

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic is_species_kind(kind_e kind);
    return kind == KIND_SPECIES_TASK || kind == KIND_SPECIES_PAIR;
  endfunction

  function automatic logic is_pair_kind(kind_e kind);
    return kind == KIND_ROBOT_PAIR || kind == KIND_SPECIES_PAIR;
  endfunction

  // tasks past the task count never count as assigned
  function automatic logic task_assigned(logic [MaskW-1:0] mask, logic [TaskW-1:0] tsk);
    return (int'(tsk) < NumTasks) && mask[tsk];
  endfunction

  function automatic logic record_hits(rec_t r, in_item_t q);
    logic [KeyW-1:0] who;
    who = is_species_kind(r.kind) ? q.query_species : q.query_robot;
    if (r.key != who) return 1'b0;
    if (!is_pair_kind(r.kind)) return r.task_first == q.query_task;
    return (r.task_first == q.query_task && task_assigned(q.assigned_tasks, r.task_second)) ||
           (r.task_second == q.query_task && task_assigned(q.assigned_tasks, r.task_first));
  endfunction

  // works out the verdict of one accepted item and keeps the record log in step
  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t v;
    kind_e     kind;
    v = NoVerdict;
    kind = kind_e'(it.entry_kind);
    if (it.cmd == CMD_INSERT) begin
      if (fail_count >= NumRecords) begin
        v.table_full = 1'b1;
      end else begin
        fail_log[fail_count].kind        = kind;
        fail_log[fail_count].key         = it.entry_key;
        fail_log[fail_count].task_first  = it.entry_task_first;
        fail_log[fail_count].task_second = is_pair_kind(kind) ? it.entry_task_second : '0;
        fail_count++;
      end
    end else if (it.has_assignment) begin
      for (int i = 0; i < fail_count; i++) begin
        if (record_hits(fail_log[i], it)) v.prune = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic in_item_t insert_item(kind_e kind, logic [KeyW-1:0] key,
                                           logic [TaskW-1:0] t1, logic [TaskW-1:0] t2);
    in_item_t it;
    it                   = '0;
    it.cmd               = CMD_INSERT;
    it.entry_kind        = kind;
    it.entry_key         = key;
    it.entry_task_first  = t1;
    it.entry_task_second = t2;
    return it;
  endfunction

  function automatic in_item_t query_item(logic has, logic [KeyW-1:0] robot,
                                          logic [KeyW-1:0] species, logic [TaskW-1:0] tsk,
                                          logic [MaskW-1:0] mask);
    in_item_t it;
    it                = '0;
    it.cmd            = CMD_QUERY;
    it.has_assignment = has;
    it.query_robot    = robot;
    it.query_species  = species;
    it.query_task     = tsk;
    it.assigned_tasks = mask;
    return it;
  endfunction

  // mostly queries aimed at stored records, the rest noise; inserts slowly fill the log
  function automatic in_item_t random_item();
    in_item_t     it;
    logic [127:0] noise;
    rec_t         r;
    noise = {$urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    if ($urandom_range(99) < 12) begin
      it.cmd = CMD_INSERT;
      return it;
    end
    it.cmd = CMD_QUERY;
    it.has_assignment = $urandom_range(99) < 90;
    if (fail_count > 0 && $urandom_range(99) < 75) begin
      r = fail_log[$urandom_range(fail_count - 1)];
      if (is_species_kind(r.kind)) it.query_species = r.key;
      else it.query_robot = r.key;
      if (is_pair_kind(r.kind) && $urandom_range(1) == 1) begin
        it.query_task = r.task_second;
        it.assigned_tasks[r.task_first] = 1'($urandom_range(1));
      end else begin
        it.query_task = r.task_first;
        if (is_pair_kind(r.kind)) it.assigned_tasks[r.task_second] = 1'($urandom_range(1));
      end
    end
    case ($urandom_range(19))
      0: it.assigned_tasks = '1;
      1: it.assigned_tasks = '0;
      default: ;
    endcase
    return it;
  endfunction

  // valid stays high between back-to-back items, lowered only for a gap
  task automatic send_item(in_item_t stim, logic typed);
    out_item_t v;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= stim;
    do @(posedge clk_i); while (!req_ch.ready);
    v = predict_verdict(stim);
    expected_verdicts.push_back(typed ? NoVerdict : v);
  endtask

  task automatic drain_results();
    if (expected_verdicts.size() != 0) begin
      req_ch.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clk_i);
    end
  endtask

  // receiver, result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no item pending: prune %0b table_full %0b",
                                  rsp_ch.data.prune, rsp_ch.data.table_full));
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        if (rsp_ch.data.prune !== oldest_verdict.prune)
          report_mismatch($sformatf("prune: expected %0b, got %0b",
                                    oldest_verdict.prune, rsp_ch.data.prune));
        if (rsp_ch.data.table_full !== oldest_verdict.table_full)
          report_mismatch($sformatf("table_full: expected %0b, got %0b",
                                    oldest_verdict.table_full, rsp_ch.data.table_full));
      end
    end
    rsp_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    fail_count     = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // empty log, then one record of each kind probed on a hit, the pair and species-task kinds also on a miss
    directed.push_back('{query_item(1'b0, 63, 63, 63, '1), 1'b1});
    directed.push_back('{query_item(1'b1, 0, 0, 0, '1), 1'b1});
    directed.push_back('{insert_item(KIND_ROBOT_TASK, 0, 0, 63), 1'b1});
    directed.push_back('{query_item(1'b1, 0, 63, 0, '0), 1'b0});
    directed.push_back('{insert_item(KIND_ROBOT_PAIR, 63, 63, 0), 1'b1});
    directed.push_back('{query_item(1'b1, 63, 0, 63, 64'h1), 1'b0});
    directed.push_back('{query_item(1'b1, 63, 0, 0, 64'h8000_0000_0000_0000), 1'b0});
    directed.push_back('{query_item(1'b1, 63, 0, 63, ~64'h1), 1'b0});
    directed.push_back('{insert_item(KIND_SPECIES_TASK, 5, 10, 63), 1'b1});
    directed.push_back('{query_item(1'b1, 62, 5, 10, '0), 1'b0});
    directed.push_back('{query_item(1'b1, 0, 5, 63, '1), 1'b0});
    directed.push_back('{query_item(1'b0, 0, 5, 0, '1), 1'b1});
    directed.push_back('{insert_item(KIND_SPECIES_PAIR, 63, 1, 2), 1'b1});
    directed.push_back('{query_item(1'b1, 1, 63, 2, '1), 1'b0});
    directed.push_back('{query_item(1'b1, 1, 63, 1, 64'h4), 1'b0});
    directed.push_back('{query_item(1'b1, 1, 63, 1, ~64'h4), 1'b0});
    directed.push_back('{query_item(1'b1, 63, 63, 63, '1), 1'b0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      send_idle_pct  = phase_send_idle[phase];
      recv_stall_pct = phase_recv_stall[phase];
      if (phase == 0) begin
        foreach (directed[i]) send_item(directed[i].stim, directed[i].typed);
      end
      repeat (PhaseItems) send_item(random_item(), 1'b0);
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
